[sv/sensor_frame_receiver_smoother_macros.svh]
// Assertion macros used by the frame receiver top level.
`ifndef SENSOR_FRAME_RECEIVER_SMOOTHER_MACROS_SVH
`define SENSOR_FRAME_RECEIVER_SMOOTHER_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define SFRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define SFRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sfrs_pkg.sv]
// Package with the types and constants of the sensor frame receiver.
package sfrs_pkg;

    localparam logic [7:0] START_BYTE  = 8'h7E;
    localparam logic [7:0] LEN_HI_BYTE = 8'h00;
    localparam logic [7:0] LEN_LO_BYTE = 8'h14;
    localparam logic [7:0] CSUM_BASE   = 8'hFF;
    localparam int unsigned PAYLOAD_LEN = 20;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HEADER  = 3'd1;
    localparam logic [2:0] ST_CSUM    = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;

    localparam logic [2:0] REG_ID_FIRST  = 3'd0;
    localparam logic [2:0] REG_ID_SECOND = 3'd1;
    localparam logic [2:0] REG_BOUND     = 3'd2;
    localparam logic [2:0] REG_ACCEL_A   = 3'd3;
    localparam logic [2:0] REG_EMG_A     = 3'd4;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        device_slot;
        logic [23:0] accel_x_smoothed;
        logic [23:0] accel_y_smoothed;
        logic [23:0] accel_z_smoothed;
        logic [15:0] emg_first;
        logic [15:0] emg_second;
        logic        round_done;
    } result_t;

    // A finished, checked frame handed from the parser to the filter.
    typedef struct packed {
        logic        good;
        logic        slot;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] e1;
        logic [15:0] e2;
    } frame_t;

endpackage

[sv/sfrs_if.sv]
// Valid/ready channel interfaces for input bytes and result words.
interface sfrs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfrs_result_if;
    logic       valid;
    logic       ready;
    logic [2:0]  status;
    logic        device_slot;
    logic [23:0] accel_x_smoothed;
    logic [23:0] accel_y_smoothed;
    logic [23:0] accel_z_smoothed;
    logic [15:0] emg_first;
    logic [15:0] emg_second;
    logic        round_done;
    modport source (output valid, output status, output device_slot,
        output accel_x_smoothed, output accel_y_smoothed, output accel_z_smoothed,
        output emg_first, output emg_second, output round_done, input ready);
    modport sink (input valid, input status, input device_slot,
        input accel_x_smoothed, input accel_y_smoothed, input accel_z_smoothed,
        input emg_first, input emg_second, input round_done, output ready);
endinterface

[sv/sfrs_ema.sv]
// One exponential average step: (a*s + (256-a)*p + 128) >> 8, two products.
module sfrs_ema #(
    parameter int W = 24
) (
    input  logic [W-1:0] prev,
    input  logic [W-1:0] sample,
    input  logic [8:0]   alpha,
    output logic [W-1:0] result
);
    logic [W+9:0] acc;
    logic [8:0]   beta;

    // Complementary weight and rounded sum.
    always_comb
    begin
        beta   = 9'd256 - alpha;
        acc    = (W+10)'(alpha) * (W+10)'(sample) + (W+10)'(beta) * (W+10)'(prev)
                 + (W+10)'(128);
        result = acc[W+7:8];
    end
endmodule

[sv/sensor_frame_receiver_smoother.sv]
// Top level: frame parser, checker and per-slot smoothing filters.
// Takes one byte per cycle with no backpressure while the result register can
// drain. After the edge that accepts its trailer byte, a frame's result word
// moves through the registers in order: the frame checks land in stage one,
// the filter memory is read into stage two, and the arithmetic lands in the
// result register, where the write-back also happens. A stalled result
// register holds the whole pipeline and the input. Accel state is kept in a
// one-port-read memory by slot, EMG state in a slot 0 register; a frame for
// the same slot is at least 24 bytes later, so no two updates overlap.
module sensor_frame_receiver_smoother #(
    parameter int DEVICES = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    sfrs_byte_if.sink   byte_ch,
    sfrs_result_if.source result_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sfrs_pkg::*;
    `include "sensor_frame_receiver_smoother_macros.svh"

    localparam int SW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

    // Configuration registers.
    logic [15:0] id0_reg, id1_reg, bound_reg;
    logic [8:0]  aa_reg, ea_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id0_reg   <= '0;
            id1_reg   <= '0;
            bound_reg <= 16'd1023;
            aa_reg    <= 9'd32;
            ea_reg    <= 9'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ID_FIRST:  id0_reg   <= cfg_data;
                REG_ID_SECOND: id1_reg   <= cfg_data;
                REG_BOUND:     bound_reg <= cfg_data;
                REG_ACCEL_A:   aa_reg    <= cfg_data[8:0];
                REG_EMG_A:     ea_reg    <= cfg_data[8:0];
                default:       ;
            endcase
        end
    end

    // Output register and pipeline stall.
    logic    out_valid_reg;
    result_t out_reg;
    logic    adv;
    assign adv           = !out_valid_reg || result_ch.ready;
    assign byte_ch.ready = adv;
    logic take;
    assign take = byte_ch.valid && adv;

    // Parser state.
    phase_t      ph_reg, ph_next;
    logic [4:0]  cnt_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  pay_reg [PAYLOAD_LEN];

    logic        trail;
    assign trail = take && ph_reg == PH_PAYLOAD && cnt_reg == 5'(PAYLOAD_LEN);

    // Next phase.
    always_comb
    begin
        ph_next = ph_reg;
        if (take)
        begin
            case (ph_reg)
                PH_HUNT:    if (byte_ch.rx_byte == START_BYTE) ph_next = PH_LEN_HI;
                PH_LEN_HI:  ph_next = (byte_ch.rx_byte == LEN_HI_BYTE) ? PH_LEN_LO : PH_HUNT;
                PH_LEN_LO:  ph_next = (byte_ch.rx_byte == LEN_LO_BYTE) ? PH_PAYLOAD : PH_HUNT;
                PH_PAYLOAD: if (cnt_reg == 5'(PAYLOAD_LEN)) ph_next = PH_HUNT;
                default:    ph_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg  <= PH_HUNT;
            cnt_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            ph_reg <= ph_next;
            if (take)
            begin
                if (ph_reg == PH_LEN_LO)
                begin
                    cnt_reg <= '0;
                    sum_reg <= '0;
                end
                else if (ph_reg == PH_PAYLOAD && cnt_reg != 5'(PAYLOAD_LEN))
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    sum_reg <= sum_reg + byte_ch.rx_byte;
                end
            end
        end
    end

    // Payload bytes are kept in place, each at its byte position.
    always_ff @(posedge clk)
    begin
        if (take && ph_reg == PH_PAYLOAD && cnt_reg != 5'(PAYLOAD_LEN))
            pay_reg[cnt_reg] <= byte_ch.rx_byte;
    end

    // Big-endian words at their fixed payload positions.
    logic [15:0] src, x_w, y_w, z_w, e1_w, e2_w;
    assign src  = {pay_reg[1], pay_reg[2]};
    assign z_w  = {pay_reg[10], pay_reg[11]};
    assign y_w  = {pay_reg[12], pay_reg[13]};
    assign x_w  = {pay_reg[14], pay_reg[15]};
    assign e1_w = {pay_reg[16], pay_reg[17]};
    assign e2_w = {pay_reg[18], pay_reg[19]};

    // Stage 1: frame checks on the trailer byte and on the length bytes.
    logic        s1_valid_reg;
    logic [2:0]  s1_status_reg, s1_status_next;
    frame_t      s1_reg, s1_next;
    logic        hit0, hit1, hit, slot;
    logic        over;
    logic        csum_ok;
    logic        hdr_err;

    assign hdr_err = take && ((ph_reg == PH_LEN_HI && byte_ch.rx_byte != LEN_HI_BYTE)
                   || (ph_reg == PH_LEN_LO && byte_ch.rx_byte != LEN_LO_BYTE));

    always_comb
    begin
        hit0    = id0_reg == src;
        hit1    = (DEVICES > 1) && (id1_reg == src);
        hit     = hit0 || hit1;
        slot    = !hit0 && hit1;
        over    = z_w > bound_reg || y_w > bound_reg || x_w > bound_reg
               || e1_w > bound_reg || e2_w > bound_reg;
        csum_ok = byte_ch.rx_byte == (CSUM_BASE - sum_reg);
    end

    // Checked frame and its status, header first, then checksum, then source, then range.
    always_comb
    begin
        s1_next.x    = x_w;
        s1_next.y    = y_w;
        s1_next.z    = z_w;
        s1_next.e1   = e1_w;
        s1_next.e2   = e2_w;
        s1_next.slot = 1'b0;
        s1_next.good = 1'b0;
        if (hdr_err)
            s1_status_next = ST_HEADER;
        else if (!csum_ok)
            s1_status_next = ST_CSUM;
        else if (!hit)
            s1_status_next = ST_UNKNOWN;
        else
        begin
            s1_next.slot   = slot;
            s1_status_next = over ? ST_RANGE : ST_OK;
            s1_next.good   = !over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= trail || hdr_err;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg        <= s1_next;
            s1_status_reg <= s1_status_next;
        end
    end

    // Filter memory: one row per slot, read registered.
    logic [71:0] amem [DEVICES];
    logic [31:0] emem_reg;
    logic [71:0] arow_reg;
    logic [SW-1:0] raddr;
    assign raddr = SW'(s1_reg.slot);
    logic [DEVICES-1:0] valid_reg;

    logic    s2_valid_reg;
    logic [2:0] s2_status_reg;
    frame_t  s2_reg;
    logic    s2_fresh_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            arow_reg <= amem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_fresh_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_fresh_reg <= !valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg        <= s1_reg;
            s2_status_reg <= s1_status_reg;
        end
    end

    // Stage 3: arithmetic and write-back.
    logic [71:0] prev_row;
    logic [23:0] nx, ny, nz;
    logic [15:0] n1, n2;
    logic [8:0]  aa, ea;
    assign prev_row = s2_fresh_reg ? 72'd0 : arow_reg;
    assign aa = (aa_reg > 9'd256) ? 9'd256 : aa_reg;
    assign ea = (ea_reg > 9'd256) ? 9'd256 : ea_reg;

    sfrs_ema #(.W(24)) u_x (.prev(prev_row[71:48]), .sample({s2_reg.x, 8'd0}),
        .alpha(aa), .result(nx));
    sfrs_ema #(.W(24)) u_y (.prev(prev_row[47:24]), .sample({s2_reg.y, 8'd0}),
        .alpha(aa), .result(ny));
    sfrs_ema #(.W(24)) u_z (.prev(prev_row[23:0]), .sample({s2_reg.z, 8'd0}),
        .alpha(aa), .result(nz));
    sfrs_ema #(.W(16)) u_e1 (.prev(emem_reg[31:16]), .sample(s2_reg.e1),
        .alpha(ea), .result(n1));
    sfrs_ema #(.W(16)) u_e2 (.prev(emem_reg[15:0]), .sample(s2_reg.e2),
        .alpha(ea), .result(n2));

    logic upd;
    logic [SW-1:0] waddr;
    assign upd   = adv && s2_valid_reg && s2_reg.good;
    assign waddr = SW'(s2_reg.slot);

    always_ff @(posedge clk)
    begin
        if (upd)
            amem[waddr] <= {nx, ny, nz};
    end

    logic [DEVICES-1:0] seen_reg, seen_next;
    logic               all;

    always_comb
    begin
        seen_next        = seen_reg;
        seen_next[waddr] = 1'b1;
        all              = &seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            seen_reg  <= '0;
            emem_reg  <= '0;
        end
        else if (upd)
        begin
            valid_reg[waddr] <= 1'b1;
            seen_reg <= all ? '0 : seen_next;
            if (!s2_reg.slot)
                emem_reg <= {n1, n2};
        end
    end

    // Next result word.
    result_t out_next;

    always_comb
    begin
        out_next        = '0;
        out_next.status = s2_status_reg;
        if (s2_status_reg == ST_RANGE)
            out_next.device_slot = s2_reg.slot;
        if (s2_valid_reg && s2_reg.good)
        begin
            out_next.device_slot      = s2_reg.slot;
            out_next.accel_x_smoothed = nx;
            out_next.accel_y_smoothed = ny;
            out_next.accel_z_smoothed = nz;
            out_next.emg_first        = s2_reg.slot ? s2_reg.e1 : n1;
            out_next.emg_second       = s2_reg.slot ? s2_reg.e2 : n2;
            out_next.round_done       = all;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign result_ch.valid            = out_valid_reg;
    assign result_ch.status           = out_reg.status;
    assign result_ch.device_slot      = out_reg.device_slot;
    assign result_ch.accel_x_smoothed = out_reg.accel_x_smoothed;
    assign result_ch.accel_y_smoothed = out_reg.accel_y_smoothed;
    assign result_ch.accel_z_smoothed = out_reg.accel_z_smoothed;
    assign result_ch.emg_first        = out_reg.emg_first;
    assign result_ch.emg_second       = out_reg.emg_second;
    assign result_ch.round_done       = out_reg.round_done;

    `SFRS_ASSERT_IMP(a_hold_stall, clk, rst_n, out_valid_reg && !result_ch.ready, !byte_ch.ready,
        "input taken while output stalled")
    `SFRS_ASSERT_NEXT(a_trail_hunt, clk, rst_n, trail, ph_reg == PH_HUNT,
        "parser did not return to hunting after trailer")
    `SFRS_ASSERT_NEXT(a_good_ok, clk, rst_n, upd, out_valid_reg && out_reg.status == ST_OK,
        "filter update without ok result")
endmodule

[test/sensor_frame_receiver_smoother_test.sv]
// Self-checking testbench for the sensor frame receiver with smoothing filters.
module sensor_frame_receiver_smoother_test;
    import sfrs_pkg::*;

    // Register index outside the register list.
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    sfrs_byte_if   byte_ch ();
    sfrs_result_if result_ch ();

    sensor_frame_receiver_smoother u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch.sink),
        .result_ch (result_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state and configuration copy.
    logic [15:0] id_first, id_second, bound;
    logic [8:0]  accel_a, emg_a;
    logic [4:0]  rx_phase;
    logic [7:0]  rx_sum;
    logic [7:0]  rx_payload [0:19];
    logic [23:0] accel_avg [0:5];
    logic [15:0] emg_avg [0:1];
    logic        slot_seen [0:1];

    logic [7:0] byte_queue [$];
    result_t    expected_results [$];
    int         fail_count;
    int         result_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         cfg_hold;

    always #4 clk = ~clk;

    function automatic logic [15:0] pay_word(logic [4:0] pos);
        return {rx_payload[pos], rx_payload[pos + 5'd1]};
    endfunction

    function automatic logic [23:0] accel_ema(logic [23:0] prev, logic [15:0] s,
                                              logic [8:0] a);
        logic [47:0] acc;
        acc = 48'(a) * (48'(s) << 8) + 48'(9'd256 - a) * 48'(prev) + 48'd128;
        return acc[31:8];
    endfunction

    function automatic logic [15:0] emg_ema(logic [15:0] prev, logic [15:0] s,
                                            logic [8:0] a);
        logic [47:0] acc;
        acc = 48'(a) * 48'(s) + 48'(9'd256 - a) * 48'(prev) + 48'd128;
        return acc[23:8];
    endfunction

    // Advance the frame predictor by one accepted byte.
    task automatic predict_byte(logic [7:0] b);
        result_t     r;
        logic [15:0] src;
        logic [8:0]  aa, ea;
        logic        slot;
        logic [2:0]  base;
        bit          hit, over;
        r = '0;
        if (rx_phase == 5'd0)
        begin
            if (b == START_BYTE)
            begin
                rx_phase = 5'd1;
                rx_sum = 8'd0;
            end
        end
        else if (rx_phase == 5'd1 || rx_phase == 5'd2)
        begin
            if (b != (rx_phase == 5'd1 ? LEN_HI_BYTE : LEN_LO_BYTE))
            begin
                rx_phase = 5'd0;
                r.status = ST_HEADER;
                expected_results.push_back(r);
            end
            else
            begin
                rx_phase++;
            end
        end
        else if (rx_phase < 5'd23)
        begin
            rx_payload[rx_phase - 5'd3] = b;
            rx_sum = rx_sum + b;
            rx_phase++;
        end
        else
        begin
            rx_phase = 5'd0;
            src = pay_word(5'd1);
            hit = 1'b0;
            slot = 1'b0;
            if (id_first == src)
                hit = 1'b1;
            else if (id_second == src)
            begin
                hit = 1'b1;
                slot = 1'b1;
            end
            base = slot ? 3'd3 : 3'd0;
            over = 1'b0;
            for (int k = 10; k < 20; k += 2)
                if (pay_word(5'(k)) > bound) over = 1'b1;
            if (b != CSUM_BASE - rx_sum)
                r.status = ST_CSUM;
            else if (!hit)
                r.status = ST_UNKNOWN;
            else if (over)
            begin
                r.status = ST_RANGE;
                r.device_slot = slot;
            end
            else
            begin
                aa = accel_a > 9'd256 ? 9'd256 : accel_a;
                ea = emg_a > 9'd256 ? 9'd256 : emg_a;
                accel_avg[base]        = accel_ema(accel_avg[base], pay_word(5'd14), aa);
                accel_avg[base + 3'd1] = accel_ema(accel_avg[base + 3'd1], pay_word(5'd12), aa);
                accel_avg[base + 3'd2] = accel_ema(accel_avg[base + 3'd2], pay_word(5'd10), aa);
                r.status = ST_OK;
                r.device_slot = slot;
                r.accel_x_smoothed = accel_avg[base];
                r.accel_y_smoothed = accel_avg[base + 3'd1];
                r.accel_z_smoothed = accel_avg[base + 3'd2];
                r.emg_first = pay_word(5'd16);
                r.emg_second = pay_word(5'd18);
                if (!slot)
                begin
                    emg_avg[0] = emg_ema(emg_avg[0], pay_word(5'd16), ea);
                    emg_avg[1] = emg_ema(emg_avg[1], pay_word(5'd18), ea);
                    r.emg_first = emg_avg[0];
                    r.emg_second = emg_avg[1];
                end
                slot_seen[slot] = 1'b1;
                r.round_done = slot_seen[0] && slot_seen[1];
                if (r.round_done)
                begin
                    slot_seen[0] = 1'b0;
                    slot_seen[1] = 1'b0;
                end
            end
            expected_results.push_back(r);
        end
    endtask

    // Queue one frame; flaws: 0 none, 1 bad length, 2 bad checksum.
    task automatic queue_frame(logic [15:0] src, logic [15:0] maxs, int flaw);
        logic [7:0]  pay [0:19];
        logic [7:0]  s;
        logic [15:0] w;
        s = 8'd0;
        for (int i = 0; i < 20; i++) pay[5'(i)] = 8'($urandom_range(0, 255));
        pay[1] = src[15:8];
        pay[2] = src[7:0];
        for (int k = 10; k < 20; k += 2)
        begin
            w = 16'($urandom_range(0, 32'(maxs)));
            pay[5'(k)] = w[15:8];
            pay[5'(k + 1)] = w[7:0];
        end
        byte_queue.push_back(START_BYTE);
        if (flaw == 1)
        begin
            byte_queue.push_back($urandom_range(0, 1) != 0 ? 8'h7E : 8'h01);
            return;
        end
        byte_queue.push_back(LEN_HI_BYTE);
        byte_queue.push_back(LEN_LO_BYTE);
        for (int i = 0; i < 20; i++)
        begin
            byte_queue.push_back(pay[5'(i)]);
            s = s + pay[5'(i)];
        end
        byte_queue.push_back(flaw == 2 ? CSUM_BASE - s + 8'd1 : CSUM_BASE - s);
    endtask

    // Write one register at an idle point and mirror it.
    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ID_FIRST:  id_first = val;
            REG_ID_SECOND: id_second = val;
            REG_BOUND:     bound = val;
            REG_ACCEL_A:   accel_a = val[8:0];
            REG_EMG_A:     emg_a = val[8:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (byte_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Byte driver; a byte that is offered stays in place until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.rx_byte <= '0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_byte(byte_ch.rx_byte);
                void'(byte_queue.pop_front());
            end
            if (byte_ch.valid && !byte_ch.ready)
            begin
                // Keep offering the same byte.
            end
            else if (byte_queue.size() != 0 && !cfg_hold &&
                     $urandom_range(0, 99) >= send_idle_pct)
            begin
                byte_ch.valid <= 1'b1;
                byte_ch.rx_byte <= byte_queue[0];
            end
            else
            begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                result_t got, want;
                got = {result_ch.status, result_ch.device_slot, result_ch.accel_x_smoothed,
                       result_ch.accel_y_smoothed, result_ch.accel_z_smoothed,
                       result_ch.emg_first, result_ch.emg_second, result_ch.round_done};
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t mismatch: expected %h, actual %h", $time, want, got);
                        fail_count++;
                    end
                end
            end
            result_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // Stimulus and phases.
    initial
    begin
        logic [15:0] ids [0:1];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cfg_hold = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        result_count = 0;
        id_first = '0;
        id_second = '0;
        bound = 16'd1023;
        accel_a = 9'd32;
        emg_a = 9'd32;
        rx_phase = 5'd0;
        rx_sum = 8'd0;
        for (int i = 0; i < 20; i++) rx_payload[5'(i)] = '0;
        for (int i = 0; i < 6; i++) accel_avg[3'(i)] = '0;
        emg_avg[0] = '0;
        emg_avg[1] = '0;
        slot_seen[0] = 1'b0;
        slot_seen[1] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset defaults, duplicate addresses, every status code.
        queue_frame(16'h0000, 16'd1023, 0);
        queue_frame(16'h0000, 16'hFFFF, 0);
        queue_frame(16'h0000, 16'd1023, 1);
        queue_frame(16'h0000, 16'd1023, 2);
        queue_frame(16'h1234, 16'd1023, 0);
        byte_queue.push_back(8'h00);
        byte_queue.push_back(8'hFF);
        drain();

        // Phases with different settings and idling.
        for (int ph = 0; ph < 8; ph++)
        begin
            cfg_hold = 1'b1;
            case (ph)
                0:
                begin
                    ids[0] = 16'hFFFF;
                    ids[1] = 16'h0000;
                end
                default:
                begin
                    ids[0] = 16'($urandom);
                    ids[1] = 16'($urandom);
                end
            endcase
            write_reg(REG_ID_FIRST, ids[0]);
            write_reg(REG_ID_SECOND, ids[1]);
            write_reg(REG_BOUND, ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0000 : 16'($urandom));
            write_reg(REG_ACCEL_A, ph == 0 ? 16'd256 : ph == 1 ? 16'd0 :
                      ph == 2 ? 16'd511 : 16'($urandom_range(0, 511)));
            write_reg(REG_EMG_A, ph == 0 ? 16'd256 : ph == 1 ? 16'd0 :
                      ph == 2 ? 16'd300 : 16'($urandom_range(0, 511)));
            write_reg(REG_UNUSED, 16'($urandom));
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 35 : 54) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 35 : 54) : 0;
            for (int f = 0; f < 6; f++)
            begin
                int pick;
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    byte_queue.push_back(8'($urandom_range(0, 255)));
                else
                    queue_frame(ids[1'($urandom_range(0, 1))] ^ (pick < 14 ? 16'h0001 : 16'h0),
                                pick < 22 ? 16'hFFFF : (bound > 16'h8000 ? 16'hFFFF : bound),
                                pick < 30 ? 1 : pick < 38 ? 2 : 0);
            end
            cfg_hold = 1'b0;
            drain();
        end

        $display("Run covered %0d results over directed frames and eight configuration phases.",
                 result_count);
        if (fail_count == 0)
            $display("PASS sensor_frame_receiver_smoother");
        else
            $display("FAIL sensor_frame_receiver_smoother");
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #2000000;
        $display("FAIL sensor_frame_receiver_smoother");
        $finish;
    end
endmodule
